/* design/utf8d_pkg.sv */
// shared types and constants for the utf-8 stream decoder
// result entry and front-to-queue push bundle; no dependencies
package utf8d_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [31:0] REPL_RESET = 32'd63;

  typedef struct packed {
    logic [31:0] code;
    logic        invalid;
    logic        eor;
    logic        eos;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } push_t;

endpackage

/* design/utf8d_front.sv */
// front end: byte classification, sequence state and result generation
// depends on utf8d_pkg
module utf8d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             is_last,
  input  logic [31:0]      repl_code,
  output utf8d_pkg::push_t push,
  output logic             seq_open
);
  import utf8d_pkg::*;

  logic [2:0]  rem_r, rem_nxt, rem_mid;
  logic [31:0] pc_r, pc_nxt, pc_mid;
  logic        cont, open;
  logic        lead_ok;
  logic [2:0]  lead_rem;
  logic [31:0] lead_pay;
  logic [31:0] shifted;
  logic        e0v, e1v, e2v;
  res_t        ent0, ent1, ent2;
  res_t        s0, s1;
  logic [1:0]  cnt;

  // lead byte decode
  always_comb begin
    lead_ok  = 1'b1;
    lead_rem = 3'd0;
    lead_pay = 32'd0;
    if (data_byte[7:5] == 3'b110) begin
      lead_rem = 3'd1;
      lead_pay = {27'd0, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_rem = 3'd2;
      lead_pay = {28'd0, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_rem = 3'd3;
      lead_pay = {29'd0, data_byte[2:0]};
    end else if (data_byte[7:2] == 6'b111110) begin
      lead_rem = 3'd4;
      lead_pay = {30'd0, data_byte[1:0]};
    end else if (data_byte[7:1] == 7'b1111110) begin
      lead_rem = 3'd5;
      lead_pay = {31'd0, data_byte[0]};
    end else if (data_byte == 8'hfe) begin
      lead_rem = 3'd5;
      lead_pay = 32'd2;
    end else if (data_byte == 8'hff) begin
      lead_rem = 3'd5;
      lead_pay = 32'd3;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    cont    = (data_byte[7:6] == 2'b10);
    open    = (rem_r != 3'd0);
    shifted = {pc_r[25:0], data_byte[5:0]};
    rem_mid = rem_r;
    pc_mid  = pc_r;
    e0v     = 1'b0;
    e1v     = 1'b0;
    ent0    = '{code: repl_code, invalid: 1'b1, eor: 1'b0, eos: 1'b0};
    ent1    = '{code: repl_code, invalid: 1'b1, eor: 1'b0, eos: 1'b0};
    ent2    = '{code: repl_code, invalid: 1'b1, eor: 1'b0, eos: 1'b0};
    if (open && cont) begin
      rem_mid = rem_r - 3'd1;
      if (rem_mid == 3'd0) begin
        e1v    = 1'b1;
        pc_mid = 32'd0;
        if (shifted != 32'd0) begin
          ent1.code    = shifted;
          ent1.invalid = 1'b0;
        end
      end else begin
        pc_mid = shifted;
      end
    end else begin
      // a broken sequence reports first, then the byte starts afresh
      e0v     = open;
      rem_mid = 3'd0;
      pc_mid  = 32'd0;
      if (!data_byte[7]) begin
        e1v          = 1'b1;
        ent1.code    = {24'd0, data_byte};
        ent1.invalid = 1'b0;
      end else if (lead_ok) begin
        rem_mid = lead_rem;
        pc_mid  = lead_pay;
      end else begin
        e1v = 1'b1;
      end
    end
    // sequence cut off by end of string
    e2v     = is_last && (rem_mid != 3'd0);
    rem_nxt = is_last ? 3'd0 : rem_mid;
    pc_nxt  = is_last ? 32'd0 : pc_mid;

    cnt = {1'b0, e0v} + {1'b0, e1v} + {1'b0, e2v};
    s0  = e0v ? ent0 : (e1v ? ent1 : ent2);
    s1  = (e0v && e1v) ? ent1 : ent2;
    if (cnt == 2'd1) begin
      s0.eor = 1'b1;
      s0.eos = is_last;
    end
    s1.eor = 1'b1;
    s1.eos = is_last;

    push.cnt = cnt;
    push.e0  = s0;
    push.e1  = s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      pc_r  <= 32'd0;
    end else if (accept) begin
      rem_r <= rem_nxt;
      pc_r  <= pc_nxt;
    end
  end

  assign seq_open = open;

endmodule

/* design/utf8d_queue.sv */
// result queue between front and back; takes up to two entries a cycle
// depends on utf8d_pkg
module utf8d_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  utf8d_pkg::push_t      push,
  input  logic                  pop,
  output utf8d_pkg::res_t       head,
  output logic                  head_valid,
  output logic [utf8d_pkg::QCW-1:0] level
);
  import utf8d_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] level_r, level_nxt;
  logic [1:0]     pcnt;

  always_comb begin
    pcnt       = push_en ? push.cnt : 2'd0;
    wr_ptr_nxt = wr_ptr_r + QAW'(pcnt);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    level_nxt  = level_r + QCW'(pcnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (pcnt != 2'd0) begin
      mem[wr_ptr_r] <= push.e0;
    end
    if (pcnt == 2'd2) begin
      mem[wr_ptr_r + QAW'(1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign head_valid = (level_r != '0);
  assign level      = level_r;

endmodule

/* design/utf8d_back.sv */
// back end: output register that drains the result queue
// depends on utf8d_pkg
module utf8d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  utf8d_pkg::res_t head,
  input  logic            head_valid,
  input  logic            out_ready,
  output logic            pop,
  output logic            out_valid,
  output utf8d_pkg::res_t out_res
);
  import utf8d_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    pop       = head_valid && (!valid_r || out_ready);
    valid_nxt = pop || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* design/utf8_stream_decoder_core.sv */
// top level of the utf-8 stream decoder: front, result queue, output stage
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// usage:
//   in_*   : one utf-8 byte per transaction in in_tdata[7:0]; in_tlast marks
//            the final byte of a string
//   out_*  : one 32-bit code point per transaction; out_tuser flags it as a
//            replacement and as the last result of its byte; out_tlast marks
//            the last result of the final byte of a string
//   cfg_*  : write of the replacement code, only while the block is idle
// a byte gives zero, one or two results; they pass through the queue and
// are then registered in the output stage. a byte is taken every cycle as
// long as the results leave at one per cycle; the single output register
// limits drain to one result per cycle; two-result bytes raise the queue level.
// in_tready is high while the 4-entry queue has room for two results.
// when the receiver stalls, results pile up in the queue and in_tready
// drops once fewer than two slots are free.
// reset clears the sequence state and the queue and sets the replacement
// code to 63 ('?').
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // is_last
  // decoded code points
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] code_point
  output logic [1:0]  out_tuser,  // [0] was_invalid, [1] end_of_run
  output logic        out_tlast,  // end_of_string
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data // replacement_code
);
  import utf8d_pkg::*;

  logic [31:0]    repl_r;
  logic           in_accept;
  push_t          push;
  logic           seq_open;
  res_t           head;
  logic           head_valid;
  logic           pop;
  logic [QCW-1:0] q_level;
  res_t           out_res;

  // replacement code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_wr_en) begin
      repl_r <= cfg_wr_data;
    end
  end

  // room for the worst case of two results per byte
  assign in_tready = (q_level <= QCW'(QDEPTH - 2));
  assign in_accept = in_tvalid && in_tready;

  utf8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_tdata),
    .is_last   (in_tlast),
    .repl_code (repl_r),
    .push      (push),
    .seq_open  (seq_open)
  );

  utf8d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_accept),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .out_ready  (out_tready),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.code;
  assign out_tuser = {out_res.eor, out_res.invalid};
  assign out_tlast = out_res.eos;

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QCW'(QDEPTH))
    else $error("result queue level beyond depth");

  // end of string is always the last result of its byte
  a_eos_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("end of string without end of run");

  // a string end closes any open sequence
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> !seq_open)
    else $error("sequence still open after last byte");

endmodule
